// File: src/bbfe_pkg.sv
`timescale 1ns / 1ps
package bbfe_pkg;

    localparam int WORD_W  = 64;
    localparam int WORDS   = 64;
    localparam int IDX_W   = $clog2(WORDS);
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int LOC_W   = 12;
    localparam int COLS    = 4096;
    localparam int ID_W    = 48;
    localparam int PRED_W  = ID_W + 1;

    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_LOAD      = 3'd1,
        OP_CLEAR     = 3'd2,
        OP_EDGE      = 3'd3,
        OP_OR        = 3'd4,
        OP_COMMIT    = 3'd5,
        OP_READ_WORD = 3'd6,
        OP_READ_PRED = 3'd7
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CLEAR = 4'b0010,
        S_READ  = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             capture;
        logic             rd;
        logic             ex;
        logic             sweep;
        logic             sweep_search;
        logic             sweep_next;
        logic [IDX_W-1:0] sweep_idx;
    } t_cmd;

endpackage

// File: src/bbfe_ctrl.sv
`timescale 1ns / 1ps
module bbfe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [2:0]    i_op,
    input  logic          i_ready,
    output logic          o_ready,
    output logic          o_valid,
    output bbfe_pkg::t_cmd o_cmd
);
    import bbfe_pkg::*;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             r_search, n_search;
    logic             r_next, n_next;
    logic             r_to_exec, n_to_exec;
    logic             r_out_valid, n_out_valid;
    logic             ex_fire;
    t_op              op_in;

    assign op_in   = t_op'(i_op);
    assign ex_fire = (r_state == S_EXEC) && (!r_out_valid || i_ready);
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    // Sequence each transaction: clear sweep or read, then execute
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_search  = r_search;
        n_next    = r_next;
        n_to_exec = r_to_exec;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cnt = '0;
                    if (op_in == OP_START) begin
                        n_state   = S_CLEAR;
                        n_search  = 1'b1;
                        n_next    = 1'b0;
                        n_to_exec = 1'b1;
                    end else if (op_in == OP_CLEAR) begin
                        n_state   = S_CLEAR;
                        n_search  = 1'b0;
                        n_next    = 1'b1;
                        n_to_exec = 1'b1;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == IDX_W'(WORDS - 1)) begin
                    n_state = r_to_exec ? S_EXEC : S_IDLE;
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: if (ex_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Track the output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (ex_fire) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_search    <= 1'b1;
            r_next      <= 1'b1;
            r_to_exec   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_search    <= n_search;
            r_next      <= n_next;
            r_to_exec   <= n_to_exec;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd.capture      = i_valid && (r_state == S_IDLE);
        o_cmd.rd           = (r_state == S_READ);
        o_cmd.ex           = ex_fire;
        o_cmd.sweep        = (r_state == S_CLEAR);
        o_cmd.sweep_search = r_search;
        o_cmd.sweep_next   = r_next;
        o_cmd.sweep_idx    = r_cnt;
    end

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_cnt == IDX_W'(WORDS - 1)) |=> (r_state != S_CLEAR))
        else $error("clear sweep overran");
    a_read_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_EXEC))
        else $error("read not followed by execute");
    a_fire_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ex_fire |=> (r_out_valid && r_state == S_IDLE))
        else $error("executed transaction produced no result");

endmodule

// File: src/bbfe_dp.sv
`timescale 1ns / 1ps
module bbfe_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bbfe_pkg::t_cmd              i_cmd,
    input  logic [2:0]                  i_op,
    input  logic [5:0]                  i_word_index,
    input  logic [63:0]                 i_word_data,
    input  logic [11:0]                 i_row_index,
    input  logic [11:0]                 i_col_index,
    input  logic                        i_row_is_local,
    input  logic                        i_col_is_local,
    input  logic                        i_replace_word,
    input  logic [47:0]                 i_vertex_id,
    output logic [63:0]                 o_read_word,
    output logic signed [48:0]          o_pred_value,
    output logic                        o_discovered,
    output logic                        o_frontier_nonempty
);
    import bbfe_pkg::*;

    // Captured transaction
    t_op               r_op;
    logic [IDX_W-1:0]  r_w;
    logic [WORD_W-1:0] r_data;
    logic [LOC_W-1:0]  r_row, r_col;
    logic              r_row_loc, r_col_loc, r_replace;
    logic [ID_W-1:0]   r_vid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= t_op'(i_op);
            r_w       <= i_word_index;
            r_data    <= i_word_data;
            r_row     <= i_row_index;
            r_col     <= i_col_index;
            r_row_loc <= i_row_is_local;
            r_col_loc <= i_col_is_local;
            r_replace <= i_replace_word;
            r_vid     <= i_vertex_id;
        end
    end

    // Bitmap and predecessor memories
    logic [WORD_W-1:0] m_cf  [WORDS];
    logic [WORD_W-1:0] m_vis [WORDS];
    logic [WORD_W-1:0] m_nf  [WORDS];
    logic [WORD_W-1:0] m_pv  [WORDS];
    logic [ID_W-1:0]   m_pt  [COLS];

    logic [WORD_W-1:0] r_rd_cf, r_rd_vis, r_rd_nf, r_rd_pv;
    logic [ID_W-1:0]   r_rd_pt;
    logic [IDX_W-1:0]  row_w, col_w, vn_addr;
    logic [BIT_W-1:0]  col_b;

    assign row_w   = r_row[LOC_W-1:BIT_W];
    assign col_w   = r_col[LOC_W-1:BIT_W];
    assign col_b   = r_col[BIT_W-1:0];
    assign vn_addr = (r_op == OP_EDGE) ? col_w : r_w;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_cf  <= m_cf[row_w];
            r_rd_vis <= m_vis[vn_addr];
            r_rd_nf  <= m_nf[vn_addr];
            r_rd_pv  <= m_pv[col_w];
            r_rd_pt  <= m_pt[r_col];
        end
    end

    // Execute: decide each write port
    logic [WORD_W-1:0] bit_c, nf_src;
    logic              hit;
    logic              cf_we, vis_we, nf_we, pv_we, pt_we;
    logic [IDX_W-1:0]  cf_addr, vis_addr, nf_addr, pv_addr;
    logic [WORD_W-1:0] cf_wd, vis_wd, nf_wd, pv_wd;
    logic [WORD_W-1:0] r_nz, n_nz;

    assign bit_c  = WORD_W'(1) << col_b;
    assign hit    = r_rd_cf[r_row[BIT_W-1:0]] && ((r_rd_vis & bit_c) == '0)
                    && ((r_rd_nf & bit_c) == '0);
    assign nf_src = r_replace ? r_data : r_rd_nf;

    always_comb begin
        cf_we = 1'b0; cf_addr = row_w; cf_wd = '0;
        vis_we = 1'b0; vis_addr = vn_addr; vis_wd = '0;
        nf_we = 1'b0; nf_addr = vn_addr; nf_wd = '0;
        pv_we = 1'b0; pv_addr = col_w; pv_wd = '0;
        pt_we = 1'b0;
        if (i_cmd.sweep) begin
            cf_addr  = i_cmd.sweep_idx;
            vis_addr = i_cmd.sweep_idx;
            nf_addr  = i_cmd.sweep_idx;
            pv_addr  = i_cmd.sweep_idx;
            cf_we    = i_cmd.sweep_search;
            vis_we   = i_cmd.sweep_search;
            pv_we    = i_cmd.sweep_search;
            nf_we    = i_cmd.sweep_next;
        end else if (i_cmd.ex) begin
            unique case (r_op)
                OP_START: begin
                    cf_we  = r_row_loc;
                    cf_wd  = WORD_W'(1) << r_row[BIT_W-1:0];
                    vis_we = r_col_loc;
                    vis_addr = col_w;
                    vis_wd = bit_c;
                    pv_we  = r_col_loc;
                    pv_wd  = bit_c;
                    pt_we  = r_col_loc;
                end
                OP_LOAD: begin
                    cf_we   = 1'b1;
                    cf_addr = r_w;
                    cf_wd   = r_data;
                end
                OP_EDGE: begin
                    nf_we = hit;
                    nf_wd = r_rd_nf | bit_c;
                    pv_we = hit;
                    pv_wd = r_rd_pv | bit_c;
                    pt_we = hit;
                end
                OP_OR: begin
                    nf_we = 1'b1;
                    nf_wd = r_rd_nf | r_data;
                end
                OP_COMMIT: begin
                    nf_we  = r_replace;
                    nf_wd  = r_data;
                    vis_we = 1'b1;
                    vis_wd = r_rd_vis | nf_src;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (cf_we)  m_cf[cf_addr]   <= cf_wd;
        if (vis_we) m_vis[vis_addr] <= vis_wd;
        if (nf_we)  m_nf[nf_addr]   <= nf_wd;
        if (pv_we)  m_pv[pv_addr]   <= pv_wd;
        if (pt_we)  m_pt[r_col]     <= r_vid;
    end

    // Track which next-frontier words are nonzero
    always_comb begin
        n_nz = r_nz;
        if (i_cmd.sweep && i_cmd.sweep_next) begin
            n_nz = '0;
        end else if (i_cmd.ex && nf_we) begin
            n_nz[nf_addr] = (nf_wd != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz <= '0;
        end else begin
            r_nz <= n_nz;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.ex) begin
            o_read_word  <= (r_op == OP_READ_WORD) ? r_rd_nf : '0;
            if (r_op != OP_READ_PRED) begin
                o_pred_value <= '0;
            end else if (r_rd_pv[col_b]) begin
                o_pred_value <= signed'({1'b0, r_rd_pt});
            end else begin
                o_pred_value <= '1;
            end
            o_discovered        <= (r_op == OP_EDGE) && hit;
            o_frontier_nonempty <= |n_nz;
        end
    end

endmodule

// File: src/bitmap_bfs_frontier_expand.sv
`timescale 1ns / 1ps
// One level of a top-down bitmap BFS. The block works on one transaction at a time.
// Most operations pass through a read state and then an execute state, which loads
// the result register. A start search or a clear of the next frontier instead sweeps
// the 64-word bitmap memories one word a cycle and then executes. After reset a
// clearing pass over all the bitmap memories runs before the first transaction is
// taken. The result register lets a new transaction be accepted while the previous
// result waits to be taken; its execute state then holds until that result is taken.
module bitmap_bfs_frontier_expand (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_op,
    input  logic [5:0]         i_word_index,
    input  logic [63:0]        i_word_data,
    input  logic [11:0]        i_row_index,
    input  logic [11:0]        i_col_index,
    input  logic               i_row_is_local,
    input  logic               i_col_is_local,
    input  logic               i_replace_word,
    input  logic [47:0]        i_vertex_id,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [63:0]        o_read_word,
    output logic signed [48:0] o_pred_value,
    output logic               o_discovered,
    output logic               o_frontier_nonempty
);
    import bbfe_pkg::*;

    t_cmd cmd;

    bbfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_ready (i_ready),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    bbfe_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_op                (i_op),
        .i_word_index        (i_word_index),
        .i_word_data         (i_word_data),
        .i_row_index         (i_row_index),
        .i_col_index         (i_col_index),
        .i_row_is_local      (i_row_is_local),
        .i_col_is_local      (i_col_is_local),
        .i_replace_word      (i_replace_word),
        .i_vertex_id         (i_vertex_id),
        .o_read_word         (o_read_word),
        .o_pred_value        (o_pred_value),
        .o_discovered        (o_discovered),
        .o_frontier_nonempty (o_frontier_nonempty)
    );

endmodule

// File: sim/bbfe_checker.sv
`timescale 1ns / 1ps
module bbfe_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [2:0]         i_op,
    input  logic [5:0]         i_word_index,
    input  logic [63:0]        i_word_data,
    input  logic [11:0]        i_row_index,
    input  logic [11:0]        i_col_index,
    input  logic               i_row_is_local,
    input  logic               i_col_is_local,
    input  logic               i_replace_word,
    input  logic [47:0]        i_vertex_id,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [63:0]        i_read_word,
    input  logic [48:0]        i_pred_value,
    input  logic               i_discovered,
    input  logic               i_frontier_nonempty,
    output int                 o_errors,
    output int                 o_pending
);
    import bbfe_pkg::*;

    typedef struct packed {
        logic [63:0] read_word;
        logic [48:0] pred_value;
        logic        discovered;
        logic        frontier_nonempty;
    } t_bfs_result;

    localparam logic [48:0] PRED_NONE = '1;

    logic [63:0] frontier_words [WORDS];
    logic [63:0] visited_words  [WORDS];
    logic [63:0] next_words     [WORDS];
    logic [47:0] parent_ids     [COLS];
    logic        parent_set     [COLS];
    t_bfs_result result_queue[$];

    assign o_pending = result_queue.size();

    // Advance the BFS level state by one transaction and return its result
    function automatic t_bfs_result bfs_level_step(
        input t_op op, input logic [5:0] widx, input logic [63:0] data,
        input logic [11:0] row, input logic [11:0] col, input logic row_loc,
        input logic col_loc, input logic repl, input logic [47:0] vid);
        t_bfs_result res;
        logic [63:0] bit_mask;
        bit_mask = 64'd1 << col[5:0];
        res = '0;
        case (op)
            OP_START: begin
                for (int i = 0; i < WORDS; i++) begin
                    frontier_words[i] = '0;
                    visited_words[i] = '0;
                end
                for (int i = 0; i < COLS; i++) parent_set[i] = 1'b0;
                if (row_loc) frontier_words[row[11:6]] = 64'd1 << row[5:0];
                if (col_loc) begin
                    visited_words[col[11:6]] = bit_mask;
                    parent_ids[col] = vid;
                    parent_set[col] = 1'b1;
                end
            end
            OP_LOAD: frontier_words[widx] = data;
            OP_CLEAR: for (int i = 0; i < WORDS; i++) next_words[i] = '0;
            OP_EDGE: begin
                if (frontier_words[row[11:6]][row[5:0]] &&
                    !(visited_words[col[11:6]] & bit_mask) &&
                    !(next_words[col[11:6]] & bit_mask)) begin
                    next_words[col[11:6]] |= bit_mask;
                    parent_ids[col] = vid;
                    parent_set[col] = 1'b1;
                    res.discovered = 1'b1;
                end
            end
            OP_OR: next_words[widx] |= data;
            OP_COMMIT: begin
                if (repl) next_words[widx] = data;
                visited_words[widx] |= next_words[widx];
            end
            OP_READ_WORD: res.read_word = next_words[widx];
            default: res.pred_value = parent_set[col] ? {1'b0, parent_ids[col]} : PRED_NONE;
        endcase
        for (int i = 0; i < WORDS; i++)
            if (next_words[i] != '0) res.frontier_nonempty = 1'b1;
        return res;
    endfunction

    // Predict on accepted inputs, compare accepted results against the oldest prediction
    always @(posedge i_clk) begin
        t_bfs_result exp_res;
        if (!i_rst_n) begin
            for (int i = 0; i < WORDS; i++) begin
                frontier_words[i] = '0;
                visited_words[i] = '0;
                next_words[i] = '0;
            end
            for (int i = 0; i < COLS; i++) parent_set[i] = 1'b0;
            result_queue.delete();
            o_errors <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (result_queue.size() == 0) begin
                    $error("result with no transaction outstanding");
                    o_errors <= o_errors + 1;
                end else begin
                    exp_res = result_queue.pop_front();
                    if (exp_res.read_word !== i_read_word)
                        $error("read_word: expected %h, actual %h",
                               exp_res.read_word, i_read_word);
                    if (exp_res.pred_value !== i_pred_value)
                        $error("pred_value: expected %h, actual %h",
                               exp_res.pred_value, i_pred_value);
                    if (exp_res.discovered !== i_discovered)
                        $error("discovered: expected %b, actual %b",
                               exp_res.discovered, i_discovered);
                    if (exp_res.frontier_nonempty !== i_frontier_nonempty)
                        $error("frontier_nonempty: expected %b, actual %b",
                               exp_res.frontier_nonempty, i_frontier_nonempty);
                    if (exp_res !== {i_read_word, i_pred_value, i_discovered,
                                     i_frontier_nonempty})
                        o_errors <= o_errors + 1;
                end
            end
            if (i_in_valid && i_in_ready)
                result_queue.push_back(bfs_level_step(t_op'(i_op), i_word_index,
                    i_word_data, i_row_index, i_col_index, i_row_is_local,
                    i_col_is_local, i_replace_word, i_vertex_id));
        end
    end

endmodule

// File: sim/tb_bitmap_bfs_frontier_expand.sv
`timescale 1ns / 1ps
module tb_bitmap_bfs_frontier_expand;
    import bbfe_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [2:0]         i_op;
    logic [5:0]         i_word_index;
    logic [63:0]        i_word_data;
    logic [11:0]        i_row_index;
    logic [11:0]        i_col_index;
    logic               i_row_is_local;
    logic               i_col_is_local;
    logic               i_replace_word;
    logic [47:0]        i_vertex_id;
    logic               o_valid;
    logic               i_ready;
    logic [63:0]        o_read_word;
    logic signed [48:0] o_pred_value;
    logic               o_discovered;
    logic               o_frontier_nonempty;
    int                 mismatch_count;
    int                 outstanding;

    localparam int RANDOM_OPS = 1850;

    bitmap_bfs_frontier_expand u_top (.*);

    bbfe_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_op(i_op), .i_word_index(i_word_index), .i_word_data(i_word_data),
        .i_row_index(i_row_index), .i_col_index(i_col_index),
        .i_row_is_local(i_row_is_local), .i_col_is_local(i_col_is_local),
        .i_replace_word(i_replace_word), .i_vertex_id(i_vertex_id),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_read_word(o_read_word), .i_pred_value(o_pred_value),
        .i_discovered(o_discovered), .i_frontier_nonempty(o_frontier_nonempty),
        .o_errors(mismatch_count), .o_pending(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Offer one transaction and hold it until accepted
    task automatic send_op(input t_op op, input logic [5:0] widx, input logic [63:0] data,
                           input logic [11:0] row, input logic [11:0] col,
                           input logic row_loc, input logic col_loc, input logic repl,
                           input logic [47:0] vid);
        bit hit;
        i_valid        <= 1'b1;
        i_op           <= op;
        i_word_index   <= widx;
        i_word_data    <= data;
        i_row_index    <= row;
        i_col_index    <= col;
        i_row_is_local <= row_loc;
        i_col_is_local <= col_loc;
        i_replace_word <= repl;
        i_vertex_id    <= vid;
        do begin
            @(negedge i_clk);
            hit = o_ready;
            @(posedge i_clk);
        end while (!hit);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
    endfunction

    // Receiver: changing stall patterns, with one long hold-off
    initial begin
        int mode;
        int run_len;
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        repeat (400) @(posedge i_clk);
        for (int n = 0; n < 300; n++) begin
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
        i_ready <= 1'b0;
        repeat (500) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 2);
            run_len = $urandom_range(10, 120);
            repeat (run_len) begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 1) == 1);
                    default: i_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Sender: directed cases, then random bursts
    initial begin
        int pick;
        int gap;
        int burst;
        t_op op;
        logic [11:0] row;
        logic [11:0] col;
        logic [5:0] widx;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_op           <= OP_START;
        i_word_index   <= '0;
        i_word_data    <= '0;
        i_row_index    <= '0;
        i_col_index    <= '0;
        i_row_is_local <= 1'b0;
        i_col_is_local <= 1'b0;
        i_replace_word <= 1'b0;
        i_vertex_id    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(OP_START, 6'd0, '0, 12'd0, 12'd0, 1'b1, 1'b1, 1'b0, '1);
        send_op(OP_READ_PRED, 6'd0, '0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0, '0);
        send_op(OP_LOAD, 6'd0, '1, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0, '0);
        send_op(OP_EDGE, 6'd0, '0, 12'd0, 12'd5, 1'b0, 1'b0, 1'b0, 48'h123456789ABC);
        send_op(OP_EDGE, 6'd0, '0, 12'd1, 12'd5, 1'b0, 1'b0, 1'b0, 48'h1);
        send_op(OP_EDGE, 6'd0, '0, 12'd2, 12'd0, 1'b0, 1'b0, 1'b0, 48'h2);
        send_op(OP_EDGE, 6'd0, '0, 12'd100, 12'd9, 1'b0, 1'b0, 1'b0, 48'h3);
        send_op(OP_OR, 6'd63, '1, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0, '0);
        send_op(OP_READ_WORD, 6'd63, '0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0, '0);
        send_op(OP_COMMIT, 6'd63, 64'hAAAA_5555_AAAA_5555, '0, '0, 1'b0, 1'b0, 1'b1, '0);
        send_op(OP_READ_WORD, 6'd63, '0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0, '0);
        send_op(OP_COMMIT, 6'd0, '0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0, '0);
        send_op(OP_READ_PRED, 6'd0, '0, 12'd0, 12'd5, 1'b0, 1'b0, 1'b0, '0);
        send_op(OP_READ_PRED, 6'd0, '0, 12'd0, 12'd4095, 1'b0, 1'b0, 1'b0, '0);
        send_op(OP_CLEAR, 6'd0, '0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0, '0);
        send_op(OP_READ_WORD, 6'd0, '0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0, '0);
        send_op(OP_START, 6'd0, '0, 12'd4095, 12'd4095, 1'b0, 1'b0, 1'b0, '0);
        send_op(OP_READ_PRED, 6'd0, '0, 12'd0, 12'd5, 1'b0, 1'b0, 1'b0, '0);
        send_op(OP_LOAD, 6'd63, '1, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0, '0);
        send_op(OP_EDGE, 6'd0, '0, 12'd4095, 12'd4095, 1'b0, 1'b0, 1'b0, '1);
        send_op(OP_READ_PRED, 6'd0, '0, 12'd0, 12'd4095, 1'b0, 1'b0, 1'b0, '0);
        send_op(OP_START, 6'd0, '0, 12'd4095, 12'd4095, 1'b1, 1'b1, 1'b0, 48'h5);
        send_op(OP_READ_PRED, 6'd0, '0, 12'd0, 12'd4095, 1'b0, 1'b0, 1'b0, '0);

        // Random part: frontier rows and destinations mostly in a narrow window
        // so that edges discover, collide and hit visited columns
        burst = 0;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) op = OP_START;
            else if (pick < 4) op = OP_CLEAR;
            else if (pick < 14) op = OP_LOAD;
            else if (pick < 59) op = OP_EDGE;
            else if (pick < 66) op = OP_OR;
            else if (pick < 76) op = OP_COMMIT;
            else if (pick < 87) op = OP_READ_WORD;
            else op = OP_READ_PRED;
            row  = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 255))
                                              : 12'($urandom_range(0, 4095));
            col  = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 511))
                                              : 12'($urandom_range(0, 4095));
            widx = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(0, 7))
                                              : 6'($urandom_range(0, 63));
            send_op(op, widx,
                    ($urandom_range(0, 3) == 0) ? rand64() & rand64() : rand64(),
                    row, col, 1'($urandom_range(0, 3) != 0),
                    1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)), rand48());
            if (burst == 0) begin
                gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = $urandom_range(1, 30);
            end else begin
                burst--;
            end
        end
        i_valid <= 1'b0;

        // Let the checker record the last accepted transaction before waiting
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
